// File: rtl/flpd_pkg.sv
// Shared constants and types for the frame-length provisioning decoder.
package flpd_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [15:0] MARK_LEN = 16'h05B8;
  localparam logic [15:0] IDX_BASE = 16'h0500;
  localparam logic [15:0] IDX_LO   = 16'h0501;
  localparam logic [15:0] IDX_HI   = 16'h0540;
  localparam logic [7:0]  LOW_MASK = 8'hFF;

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_LOCKED = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [1:0] ST_CONT   = 2'd0;
  localparam logic [1:0] ST_DWELL  = 2'd1;
  localparam logic [1:0] ST_LOCKED = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_RDATA = 6'b000100,
    S_CHECK = 6'b001000,
    S_SUM   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  typedef struct packed {
    logic                clear;
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

endpackage

// File: rtl/flpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module flpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/flpd_store.sv
// Byte store: RAM plus per-entry valid bits and shadow copies of bytes 0..2.
module flpd_store (
  input  logic                  clk,
  input  logic                  rst,
  input  flpd_pkg::store_req_t  req,
  output logic [7:0]            rdata,
  output logic [7:0]            byte0,
  output logic [7:0]            byte1,
  output logic [7:0]            byte2
);

  logic [flpd_pkg::STORE_DEPTH-1:0] valid;
  logic                             rd_ok;
  logic [7:0]                       ram_q;

  flpd_ram #(
    .WIDTH(8),
    .DEPTH(flpd_pkg::STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (req.we),
    .waddr(req.waddr),
    .wdata(req.wdata),
    .re   (req.re),
    .raddr(req.raddr),
    .rdata(ram_q)
  );

  // entries not written since reset or lock read as zero
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
      rd_ok <= 1'b0;
      byte0 <= '0;
      byte1 <= '0;
      byte2 <= '0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
        if (req.waddr == flpd_pkg::STORE_AW'(0)) byte0 <= req.wdata;
        if (req.waddr == flpd_pkg::STORE_AW'(1)) byte1 <= req.wdata;
        if (req.waddr == flpd_pkg::STORE_AW'(2)) byte2 <= req.wdata;
      end
      if (req.re) begin
        rd_ok <= valid[req.raddr];
      end
    end
  end

  assign rdata = rd_ok ? ram_q : 8'd0;

endmodule

// File: rtl/frame_length_provisioning_decoder.sv
// Frame-length provisioning decoder: lock search, byte capture and checksum walk.
// Reads pass through S_RDATA and data frames from the locked sender through S_CHECK;
// a data frame that triggers the checksum then walks S_SUM, which reads one stored
// byte per cycle from the RAM read port. All other items go from S_EXEC to S_FIN.
// Handshake: one item at a time; a stalled result holds the block.
// Reset: synchronous; all control state cleared, store valid bits cleared at once.
module frame_length_provisioning_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] frame_length, [16] dest_broadcast, [64:17] sender_mac, [72:65] read_index
  input  logic [79:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [2] decoded, [10:3] name_len, [18:11] key_len,
  // [26:19] spare_len, [34:27] read_byte
  output logic [39:0] m_axis_tdata
);

  flpd_pkg::state_t     state;
  flpd_pkg::store_req_t sreq;

  logic [1:0]  phase;
  logic [15:0] prev_length;
  logic [15:0] first_index_length;
  logic [15:0] length_overhead;
  logic [47:0] locked_sender;
  logic [7:0]  high_index;

  logic        in_kind;
  logic [15:0] in_len;
  logic        in_bcast;
  logic [47:0] in_mac;
  logic [7:0]  in_ridx;

  logic [7:0]  pos;
  logic [1:0]  res_status;
  logic        res_decoded;
  logic [7:0]  res_rbyte;

  logic [8:0]  ra;
  logic        rd_pend;
  logic [7:0]  rd_idx;
  logic [15:0] sum;
  logic        hi_ok;
  logic        lo_ok;

  logic [7:0]  rdata, byte0, byte1, byte2;
  logic [15:0] adj;
  logic [15:0] adj_lock;
  logic [7:0]  pos_calc;
  logic        is_index;
  logic [7:0]  tm1, tm2;
  logic        exec_lock;

  assign s_axis_tready = (state == flpd_pkg::S_IDLE);

  assign adj      = in_len - length_overhead;
  assign adj_lock = in_len - length_overhead - flpd_pkg::IDX_LO;
  assign is_index = (adj >= flpd_pkg::IDX_LO) && (adj <= flpd_pkg::IDX_HI);
  assign pos_calc = {high_index[5:0], 2'b00} + adj[15:8] - 8'd1;
  assign tm1      = byte0 - 8'd1;
  assign tm2      = byte0 - 8'd2;

  assign exec_lock = (state == flpd_pkg::S_EXEC) && (in_kind == flpd_pkg::KIND_FRAME)
                     && in_bcast && (phase == flpd_pkg::PH_SEARCH)
                     && (in_len > flpd_pkg::IDX_LO) && (prev_length == flpd_pkg::MARK_LEN)
                     && (in_len != flpd_pkg::MARK_LEN) && (first_index_length == in_len);

  always_comb begin
    sreq       = '0;
    sreq.clear = exec_lock;
    sreq.wdata = adj[7:0] & flpd_pkg::LOW_MASK;
    sreq.waddr = pos_calc;
    if (state == flpd_pkg::S_EXEC) begin
      sreq.we = (in_kind == flpd_pkg::KIND_FRAME) && in_bcast
                && (phase == flpd_pkg::PH_LOCKED) && (in_mac == locked_sender)
                && !is_index && (in_len != flpd_pkg::MARK_LEN);
      sreq.re    = (in_kind == flpd_pkg::KIND_READ);
      sreq.raddr = in_ridx;
    end else if (state == flpd_pkg::S_SUM) begin
      sreq.re    = (ra < {1'b0, byte0});
      sreq.raddr = ra[7:0];
    end
  end

  flpd_store u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (sreq),
    .rdata(rdata),
    .byte0(byte0),
    .byte1(byte1),
    .byte2(byte2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= flpd_pkg::S_IDLE;
      phase              <= flpd_pkg::PH_SEARCH;
      prev_length        <= '0;
      first_index_length <= '0;
      length_overhead    <= '0;
      locked_sender      <= '0;
      high_index         <= '0;
      m_axis_tvalid      <= 1'b0;
      rd_pend            <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != flpd_pkg::S_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        flpd_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            in_kind  <= s_axis_tuser;
            in_len   <= s_axis_tdata[15:0];
            in_bcast <= s_axis_tdata[16];
            in_mac   <= s_axis_tdata[64:17];
            in_ridx  <= s_axis_tdata[72:65];
            state    <= flpd_pkg::S_EXEC;
          end
        end
        flpd_pkg::S_EXEC: begin
          res_decoded <= 1'b0;
          res_rbyte   <= 8'd0;
          pos         <= pos_calc;
          if (in_kind == flpd_pkg::KIND_READ) begin
            res_status <= flpd_pkg::ST_CONT;
            state      <= flpd_pkg::S_RDATA;
          end else if (!in_bcast) begin
            res_status <= flpd_pkg::ST_CONT;
            state      <= flpd_pkg::S_FIN;
          end else begin
            priority if (phase == flpd_pkg::PH_SEARCH) begin
              state <= flpd_pkg::S_FIN;
              if (in_len > flpd_pkg::IDX_LO) begin
                if (exec_lock) begin
                  length_overhead <= adj_lock;
                  locked_sender   <= in_mac;
                  phase           <= flpd_pkg::PH_LOCKED;
                  res_status      <= flpd_pkg::ST_LOCKED;
                end else begin
                  res_status <= flpd_pkg::ST_DWELL;
                  if ((prev_length == flpd_pkg::MARK_LEN)
                      && (in_len != flpd_pkg::MARK_LEN)) begin
                    first_index_length <= in_len;
                  end
                  prev_length <= in_len;
                end
              end else begin
                res_status <= flpd_pkg::ST_CONT;
              end
            end else if (phase == flpd_pkg::PH_LOCKED) begin
              res_status <= flpd_pkg::ST_CONT;
              if ((in_mac == locked_sender) && !is_index
                  && (in_len != flpd_pkg::MARK_LEN)) begin
                state <= flpd_pkg::S_CHECK;
              end else begin
                state <= flpd_pkg::S_FIN;
              end
              if (in_mac == locked_sender) begin
                if (is_index) begin
                  high_index <= adj[7:0] - flpd_pkg::IDX_BASE[7:0];
                end else if (in_len == flpd_pkg::MARK_LEN) begin
                  high_index <= 8'd0;
                end
              end
            end else begin
              res_status <= flpd_pkg::ST_DONE;
              state      <= flpd_pkg::S_FIN;
            end
          end
        end
        flpd_pkg::S_RDATA: begin
          res_rbyte <= rdata;
          state     <= flpd_pkg::S_FIN;
        end
        flpd_pkg::S_CHECK: begin
          ra      <= '0;
          rd_pend <= 1'b0;
          sum     <= '0;
          hi_ok   <= 1'b0;
          lo_ok   <= 1'b0;
          if ((byte0 >= 8'd3) && (pos >= tm1)) begin
            state <= flpd_pkg::S_SUM;
          end else begin
            state <= flpd_pkg::S_FIN;
          end
        end
        flpd_pkg::S_SUM: begin
          if (rd_pend) begin
            if (rd_idx < tm2) begin
              sum <= sum + {8'd0, rdata};
            end
            if (rd_idx == tm2) begin
              hi_ok <= (rdata == sum[15:8]);
            end
            if (rd_idx == tm1) begin
              lo_ok <= (rdata == sum[7:0]);
            end
          end
          if (ra < {1'b0, byte0}) begin
            rd_pend <= 1'b1;
            rd_idx  <= ra[7:0];
            ra      <= ra + 9'd1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              if (hi_ok && lo_ok) begin
                phase       <= flpd_pkg::PH_DONE;
                res_decoded <= 1'b1;
              end
              state <= flpd_pkg::S_FIN;
            end
          end
        end
        flpd_pkg::S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'd0, res_rbyte, byte0 - 8'd5 - byte1 - byte2,
                              byte2, byte1, res_decoded, res_status};
            state         <= flpd_pkg::S_IDLE;
          end
        end
        default: state <= flpd_pkg::S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_decoded_sets_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2]) |-> (phase == flpd_pkg::PH_DONE))
    else $error("decoded result without complete phase");

  a_locked_sets_phase: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[1:0] == flpd_pkg::ST_LOCKED))
    |-> (phase != flpd_pkg::PH_SEARCH))
    else $error("lock reported while still searching");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == flpd_pkg::S_SUM) |-> (ra <= {1'b0, byte0}))
    else $error("checksum walk ran past total");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == flpd_pkg::S_SUM) |=> $stable(byte0))
    else $error("store total changed during checksum walk");
`endif

endmodule
